// ----- rtl/dna_reversal_variant_matcher_macros.svh -----
// assertion macros shared by the rtl of the variant matcher
// expects clk_i and rst_ni in the scope of each use
`ifndef DNA_REVERSAL_VARIANT_MATCHER_MACROS_SVH
`define DNA_REVERSAL_VARIANT_MATCHER_MACROS_SVH

// implication checked at every clock edge outside reset
`define DRVM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define DRVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/drvm_pkg.sv -----
// shared types and constants of the dna reversal variant matcher
// no dependencies
package drvm_pkg;

  localparam int DefaultMaxMarker = 32;
  localparam int CountW           = 24;
  localparam int CodesW           = 64;
  localparam int LengthW          = 6;
  localparam int CfgIdxW          = 8;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegMarkerCodes  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMarkerLength = 8'd1;

  localparam logic [7:0] CharA = 8'h41;
  localparam logic [7:0] CharC = 8'h43;
  localparam logic [7:0] CharG = 8'h47;

  typedef enum logic [1:0] {
    CODE_A = 2'd0,
    CODE_C = 2'd1,
    CODE_G = 2'd2,
    CODE_N = 2'd3
  } code_e;

  typedef struct packed {
    logic              match_here;
    logic [CountW-1:0] match_count;
    logic              sequence_end;
  } result_t;

endpackage

// ----- rtl/drvm_match.sv -----
// window compare: marker or marker with one contiguous segment reversed
// depends on drvm_pkg for the default depth
module drvm_match #(
  parameter int MAX_MARKER = drvm_pkg::DefaultMaxMarker,
  localparam int LW = $clog2(MAX_MARKER + 1)
) (
  input  logic [MAX_MARKER-1:0][1:0] window_i,
  input  logic [MAX_MARKER-1:0][1:0] marker_i,
  input  logic [LW-1:0]              len_i,
  output logic                       hit_o
);

  // window and marker are both indexed by age, newest at zero
  always_comb begin
    logic bad;
    int   r;
    hit_o = 1'b0;
    for (int p = 0; p < MAX_MARKER; p++) begin
      for (int q = p; q < MAX_MARKER; q++) begin
        bad = 1'b0;
        for (int a = 0; a < MAX_MARKER; a++) begin
          r = p + q - a;
          if (a >= p && a <= q) begin
            bad = bad | (window_i[a] != marker_i[r]);
          end else if (a < int'(len_i)) begin
            bad = bad | (window_i[a] != marker_i[a]);
          end
        end
        hit_o = hit_o | ((q < int'(len_i)) && !bad);
      end
    end
  end

endmodule

// ----- rtl/dna_reversal_variant_matcher.sv -----
// top level of the dna reversal variant matcher
// depends on drvm_pkg, drvm_match and dna_reversal_variant_matcher_macros.svh
//
// channel | dir | handshake                  | payload
// input   | in  | in_valid_i / in_stall_o    | symbol_char_i, last_symbol_i
// result  | out | out_valid_o / out_stall_i  | match_here_o, match_count_o, sequence_end_o
// config  | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one item per cycle unless in_stall_o; each result is registered into out_q or skid_q
// the single compare stage lies between the window and the output register
// a two-entry output register with skid keeps in_stall_o registered
// reset clears window, fill, count and config; no clearing pass is needed
// config writes are always taken, ready stays high
`include "dna_reversal_variant_matcher_macros.svh"

module dna_reversal_variant_matcher #(
  parameter int MAX_MARKER = drvm_pkg::DefaultMaxMarker
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   symbol_char_i,
  input  logic                         last_symbol_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         match_here_o,
  output logic [drvm_pkg::CountW-1:0]  match_count_o,
  output logic                         sequence_end_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [drvm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [drvm_pkg::CodesW-1:0]  cfg_data_i
);

  localparam int LW = $clog2(MAX_MARKER + 1);

  logic [drvm_pkg::CodesW-1:0] codes_q, codes_d;
  logic [LW-1:0]               len_q, len_d;
  logic [MAX_MARKER-1:0][1:0]  mk_q, mk_d;
  logic [MAX_MARKER-1:0][1:0]  win_q, win_d;
  logic [LW-1:0]               fill_q, fill_d;
  logic [drvm_pkg::CountW-1:0] count_q, count_d;
  logic                        out_valid_q, out_valid_d;
  logic                        skid_valid_q, skid_valid_d;
  drvm_pkg::result_t           out_q, skid_q, res;
  logic                        load_out, load_skid, out_from_skid;

  logic                         in_acc, out_take, cfg_wr, hit_raw, hit;
  logic [drvm_pkg::LengthW-1:0] raw_len;
  logic [LW-1:0]                fill_inc;
  logic [drvm_pkg::CountW-1:0]  count_nxt;
  drvm_pkg::code_e              code;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign raw_len     = cfg_data_i[drvm_pkg::LengthW-1:0];

  // marker is stored realigned to window age order
  always_comb begin
    int idx;
    codes_d = codes_q;
    len_d   = len_q;
    if (cfg_wr && cfg_index_i == drvm_pkg::RegMarkerCodes) begin
      codes_d = cfg_data_i;
    end
    if (cfg_wr && cfg_index_i == drvm_pkg::RegMarkerLength) begin
      if (raw_len == '0) begin
        len_d = LW'(1);
      end else if (int'(raw_len) > MAX_MARKER) begin
        len_d = LW'(MAX_MARKER);
      end else begin
        len_d = LW'(raw_len);
      end
    end
    for (int b = 0; b < MAX_MARKER; b++) begin
      idx = int'(len_d) - 1 - b;
      if (b < int'(len_d)) begin
        mk_d[b] = codes_d[2*idx +: 2];
      end else begin
        mk_d[b] = 2'b00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= '0;
      len_q   <= LW'(1);
      mk_q    <= '0;
    end else if (cfg_wr) begin
      codes_q <= codes_d;
      len_q   <= len_d;
      mk_q    <= mk_d;
    end
  end

  // symbol path
  always_comb begin
    case (symbol_char_i)
      drvm_pkg::CharA: code = drvm_pkg::CODE_A;
      drvm_pkg::CharC: code = drvm_pkg::CODE_C;
      drvm_pkg::CharG: code = drvm_pkg::CODE_G;
      default:         code = drvm_pkg::CODE_N;
    endcase
  end

  always_comb begin
    win_d[0] = code;
    for (int a = 1; a < MAX_MARKER; a++) begin
      win_d[a] = win_q[a-1];
    end
  end

  drvm_match #(
    .MAX_MARKER(MAX_MARKER)
  ) u_match (
    .window_i(win_d),
    .marker_i(mk_q),
    .len_i   (len_q),
    .hit_o   (hit_raw)
  );

  assign in_acc    = in_valid_i & ~skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign out_take  = out_valid_q & ~out_stall_i;

  assign fill_inc  = (int'(fill_q) == MAX_MARKER) ? fill_q : fill_q + LW'(1);
  assign hit       = hit_raw & (fill_inc >= len_q);
  assign count_nxt = (hit && count_q != drvm_pkg::CountMax) ? count_q + 1'b1 : count_q;

  assign res = '{match_here: hit, match_count: count_nxt, sequence_end: last_symbol_i};

  assign fill_d  = last_symbol_i ? '0 : fill_inc;
  assign count_d = last_symbol_i ? '0 : count_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      count_q <= '0;
    end else if (in_acc) begin
      win_q   <= last_symbol_i ? '0 : win_d;
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  // output register with skid
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_valid_d = 1'b1;
        load_out    = 1'b1;
      end else begin
        skid_valid_d = 1'b1;
        load_skid    = 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        load_out      = 1'b1;
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_from_skid ? skid_q : res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_here_o   = out_q.match_here;
  assign match_count_o  = out_q.match_count;
  assign sequence_end_o = out_q.sequence_end;

  `DRVM_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
  `DRVM_ASSERT_IMPL(a_fill_bound, 1'b1, int'(fill_q) <= MAX_MARKER, "fill beyond window depth")
  `DRVM_ASSERT_NEXT(a_last_clears, in_acc && last_symbol_i, fill_q == '0 && count_q == '0, "sequence state not cleared")
  `DRVM_ASSERT_NEXT(a_count_mono, in_acc && !last_symbol_i, count_q >= $past(count_q), "count went down")

endmodule
